// File: hdl/kpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpc_pkg
// Shared types, key codes and operator codes for the keypad calculator.
// ----------------------------------------------------------------------------
package kpc_pkg;

    localparam int STACK_DEPTH_DEF   = 4;
    localparam int FRACTION_BITS_DEF = 32;
    localparam int VALUE_W           = 64;

    // key codes
    typedef enum logic [2:0] {
        KEY_DIGIT  = 3'd0,
        KEY_POINT  = 3'd1,
        KEY_PLUS   = 3'd2,
        KEY_MINUS  = 3'd3,
        KEY_TIMES  = 3'd4,
        KEY_DIVIDE = 3'd5,
        KEY_EQUALS = 3'd6,
        KEY_CLEAR  = 3'd7
    } t_key;

    // pending operator codes
    typedef enum logic [2:0] {
        OPR_NONE  = 3'd0,
        OPR_PLUS  = 3'd1,
        OPR_MINUS = 3'd2,
        OPR_TIMES = 3'd3,
        OPR_DIV   = 3'd4
    } t_opr;

    // arithmetic unit commands
    typedef enum logic [2:0] {
        ALU_ADD = 3'd0,
        ALU_SUB = 3'd1,
        ALU_MUL = 3'd2,
        ALU_DIV = 3'd3,
        ALU_PASS = 3'd4
    } t_alu_op;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIGIT,
        ST_CHECK,
        ST_START,
        ST_WAIT,
        ST_FINISH,
        ST_OUT
    } t_state;

    // request and response between sequencer and arithmetic unit
    typedef struct packed {
        logic         start;
        t_alu_op      op;
        logic [63:0]  lhs;
        logic [63:0]  rhs;
    } t_alu_req;

    typedef struct packed {
        logic         done;
        logic         err;
        logic [63:0]  result;
    } t_alu_rsp;

    function automatic logic [1:0] f_prec(input t_opr o);
        logic [1:0] p;
        case (o)
            OPR_NONE:  p = 2'd0;
            OPR_PLUS:  p = 2'd1;
            OPR_MINUS: p = 2'd1;
            OPR_TIMES: p = 2'd2;
            default:   p = 2'd3;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

// File: hdl/keypad_precedence_calculator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_precedence_calculator_unit
// Keypad calculator with operator precedence on a stack of pending terms.
// ----------------------------------------------------------------------------
// Usage: one key transaction on i_valid/o_stall gives one result transaction
// on o_valid/i_stall (shown value, result flag, error flag).
// A key is taken only while the sequencer is idle; o_stall is high otherwise.
// Digit, point and clear keys pass through the digit step and then the output
// step, which loads the result register and raises o_valid. An operator or
// equals key passes through the check step, then a start and a wait step on
// the shared arithmetic unit for each collapsed term, then the finish and
// output steps, with up to STACK_DEPTH-1 collapses.
// Digit entry (times ten, digit times place value) is done in plain logic.
// The result register holds the transaction while i_stall is high; the
// sequencer waits in its output step until the register is free, so a
// stalled receiver backs up into o_stall after at most one more key.
// Reset (synchronous, i_rst_n low) empties the stack, clears the entry and
// display, and drops o_valid.
// ----------------------------------------------------------------------------
module keypad_precedence_calculator_unit #(
    parameter int STACK_DEPTH   = kpc_pkg::STACK_DEPTH_DEF,
    parameter int FRACTION_BITS = kpc_pkg::FRACTION_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire logic [2:0]   i_op,
    input  wire logic [3:0]   i_digit,
    output logic              o_valid,
    input  wire logic         i_stall,
    output logic signed [63:0] o_shown_value,
    output logic              o_is_result,
    output logic              o_error
);
    import kpc_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int IW = $clog2(STACK_DEPTH);
    localparam int PLACE_N = 20;
    localparam logic [63:0] MAXV  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ONE   = 64'd1 << FRACTION_BITS;

    function automatic logic [63:0] f_pow10(input int k);
        logic [63:0] p;
        p = 64'd1;
        for (int j = 0; j < k; j++) p = p * 64'd10;
        return p;
    endfunction

    // place value table: one over ten to the power of the index
    logic [63:0] w_ptab [PLACE_N];
    for (genvar g = 0; g < PLACE_N; g++) begin : g_place
        localparam logic [63:0] PV = ONE / f_pow10(g);
        assign w_ptab[g] = PV;
    end

    t_state       r_st, n_st;
    logic [63:0]  r_tv [STACK_DEPTH];
    t_opr         r_to [STACK_DEPTH];
    logic [CW-1:0] r_cnt;
    logic [63:0]  r_entry, r_disp;
    logic [4:0]   r_pidx;
    logic         r_pt, r_fresh, r_showres, r_err;
    t_key         r_key;
    logic [3:0]   r_dig;
    logic         r_oval;
    logic [63:0]  r_oval_v;
    logic         r_ores, r_oerr;

    t_alu_req     w_req;
    t_alu_rsp     w_rsp;

    kpc_alu #(.FRACTION_BITS(FRACTION_BITS)) u_alu (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp)
    );

    wire w_acc = i_valid && !o_stall;
    assign o_stall = (r_st != ST_IDLE);

    // output register free or draining this cycle
    logic w_ofree;
    assign w_ofree = !r_oval || !i_stall;

    // top of stack helpers
    logic [IW-1:0] w_top, w_below;
    assign w_top   = IW'(r_cnt - CW'(1));
    assign w_below = IW'(r_cnt - CW'(2));
    t_opr w_topop;
    assign w_topop = (r_cnt != '0) ? r_to[w_top] : OPR_NONE;
    logic w_can;
    assign w_can = (r_cnt > CW'(1)) && (f_prec(r_to[w_top]) <= f_prec(r_to[w_below]));

    // digit arithmetic: entry value after fresh check
    logic         w_isfresh;
    logic [63:0]  w_ent, w_plc, w_add_i;
    logic [4:0]   w_pidx, w_pidx_nx;
    assign w_isfresh = r_fresh || (w_topop != OPR_NONE);
    assign w_ent  = w_isfresh ? 64'd0 : r_entry;
    assign w_pidx = w_isfresh ? 5'd1 : r_pidx;
    assign w_plc  = w_ptab[w_pidx];
    assign w_pidx_nx = (w_pidx == 5'(PLACE_N - 1)) ? w_pidx : w_pidx + 5'd1;
    logic         w_pt;
    assign w_pt  = w_isfresh ? 1'b0 : r_pt;
    assign w_add_i = {60'd0, r_dig} << FRACTION_BITS;

    // arithmetic requests: collapse of top two terms
    always_comb begin
        w_req.start = 1'b0;
        w_req.op    = ALU_PASS;
        w_req.lhs   = 64'd0;
        w_req.rhs   = 64'd0;
        if (r_st == ST_START) begin
            w_req.start = 1'b1;
            w_req.lhs   = r_tv[w_below];
            w_req.rhs   = r_tv[w_top];
            case (r_to[w_below])
                OPR_PLUS:  w_req.op = ALU_ADD;
                OPR_MINUS: w_req.op = ALU_SUB;
                OPR_TIMES: w_req.op = ALU_MUL;
                OPR_DIV:   w_req.op = ALU_DIV;
                default:   w_req.op = ALU_PASS;
            endcase
        end
    end

    // digit value products (times ten by shifts, place value times digit, unsigned)
    logic [67:0] w_ten_w, w_fr_full;
    logic [63:0] w_frac_d;
    assign w_ten_w   = ({4'd0, w_ent} << 3) + ({4'd0, w_ent} << 1) + {4'd0, w_add_i};
    assign w_fr_full = w_plc * r_dig;
    assign w_frac_d  = w_fr_full[63:0];
    logic [63:0] w_dent;
    logic        w_dovf;
    always_comb begin
        if (!w_pt) begin
            w_dovf = (w_ten_w > {4'd0, MAXV});
            w_dent = w_dovf ? MAXV : w_ten_w[63:0];
        end else begin
            w_dovf = (w_ent > MAXV - w_frac_d);
            w_dent = w_dovf ? MAXV : (w_ent + w_frac_d);
        end
    end

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: if (w_acc) begin
                if (t_key'(i_op) == KEY_DIGIT || t_key'(i_op) == KEY_POINT ||
                    t_key'(i_op) == KEY_CLEAR) n_st = ST_DIGIT;
                else n_st = ST_CHECK;
            end
            ST_DIGIT:  n_st = ST_OUT;
            ST_CHECK:  n_st = w_can ? ST_START : ST_FINISH;
            ST_START:  n_st = ST_WAIT;
            ST_WAIT:   if (w_rsp.done) n_st = ST_CHECK;
            ST_FINISH: n_st = ST_OUT;
            ST_OUT:    if (w_ofree) n_st = ST_IDLE;
            default:   n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= ST_IDLE;
        else r_st <= n_st;
    end

    // stack and entry registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STACK_DEPTH; k++) begin
                r_tv[k] <= 64'd0;
                r_to[k] <= OPR_NONE;
            end
            r_cnt <= '0; r_entry <= 64'd0; r_pt <= 1'b0; r_pidx <= 5'd1;
            r_fresh <= 1'b0; r_disp <= 64'd0; r_showres <= 1'b0; r_err <= 1'b0;
        end else begin
            case (r_st)
                ST_IDLE: if (w_acc) begin
                    r_key <= t_key'(i_op);
                    r_dig <= i_digit;
                    r_err <= 1'b0;
                    if (t_key'(i_op) != KEY_DIGIT && t_key'(i_op) != KEY_POINT &&
                        t_key'(i_op) != KEY_CLEAR) begin
                        if (r_cnt == '0 && t_key'(i_op) != KEY_EQUALS) begin
                            r_tv[0] <= 64'd0;
                            r_cnt   <= CW'(1);
                        end
                        if (t_key'(i_op) == KEY_EQUALS) begin
                            if (r_cnt != '0) r_to[w_top] <= OPR_NONE;
                        end else begin
                            r_to[(r_cnt == '0) ? IW'(0) : w_top] <= t_opr'(i_op - 3'd1);
                        end
                    end
                end
                ST_DIGIT: begin
                    case (r_key)
                        KEY_DIGIT: if (r_dig <= 4'd9) begin
                            if (w_isfresh) r_fresh <= 1'b0;
                            r_entry <= w_dent;
                            r_pt    <= w_pt;
                            r_pidx  <= w_pt ? w_pidx_nx : w_pidx;
                            r_err   <= w_dovf;
                            if (r_cnt != '0 && w_topop == OPR_NONE) begin
                                r_tv[w_top] <= w_dent;
                            end else if (r_cnt < CW'(STACK_DEPTH)) begin
                                r_tv[IW'(r_cnt)] <= w_dent;
                                r_to[IW'(r_cnt)] <= OPR_NONE;
                                r_cnt <= r_cnt + CW'(1);
                            end else begin
                                r_tv[IW'(STACK_DEPTH - 1)] <= w_dent;
                                r_to[IW'(STACK_DEPTH - 1)] <= OPR_NONE;
                            end
                            r_disp    <= w_dent;
                            r_showres <= 1'b0;
                        end
                        KEY_POINT: r_pt <= 1'b1;
                        KEY_CLEAR: begin
                            r_entry <= 64'd0; r_pt <= 1'b0; r_pidx <= 5'd1;
                            r_disp <= 64'd0; r_showres <= 1'b0;
                        end
                        default: ;
                    endcase
                end
                ST_WAIT: if (w_rsp.done) begin
                    r_tv[w_below] <= w_rsp.result;
                    r_to[w_below] <= r_to[w_top];
                    r_cnt <= r_cnt - CW'(1);
                    if (w_rsp.err) r_err <= 1'b1;
                end
                ST_FINISH: if (r_key == KEY_EQUALS) begin
                    r_disp    <= (r_cnt != '0) ? r_tv[w_top] : 64'd0;
                    r_fresh   <= 1'b1;
                    r_showres <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_oval <= 1'b0;
        else if (r_st == ST_OUT && w_ofree) r_oval <= 1'b1;
        else if (!i_stall) r_oval <= 1'b0;
    end
    always_ff @(posedge i_clk) begin
        if (r_st == ST_OUT && w_ofree) begin
            r_oval_v <= r_disp;
            r_ores   <= r_showres;
            r_oerr   <= r_err;
        end
    end

    assign o_valid       = r_oval;
    assign o_shown_value = r_oval_v;
    assign o_is_result   = r_ores;
    assign o_error       = r_oerr;

    // assertions
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != ST_IDLE) |-> o_stall) else $error("key taken while busy");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(STACK_DEPTH)) else $error("stack count overflow");
    a_one_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_OUT && !i_stall && r_oval) |=> (r_st == ST_IDLE))
        else $error("result not released");
endmodule
`default_nettype wire

// File: hdl/kpc_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpc_alu
// Shared saturating fixed point unit: add, subtract, multiply, divide.
// Multiply accumulates four 32x32 partial products in turn; divide is
// restoring, one quotient bit per cycle into a 128-bit quotient.
// ----------------------------------------------------------------------------
module kpc_alu #(
    parameter int FRACTION_BITS = kpc_pkg::FRACTION_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire kpc_pkg::t_alu_req  i_req,
    output kpc_pkg::t_alu_rsp       o_rsp
);
    import kpc_pkg::*;

    localparam logic [63:0] MAXV = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MINV = 64'h8000_0000_0000_0000;

    typedef enum logic [2:0] {
        A_IDLE, A_MUL, A_MULFIN, A_DIV, A_DIVFIN, A_DONE
    } t_astate;

    t_astate      r_st, n_st;
    logic [63:0]  r_x, r_y;
    logic         r_neg;
    logic [127:0] r_acc;
    logic [1:0]   r_pp;
    logic [6:0]   r_cnt;
    logic [127:0] r_num;
    logic [64:0]  r_rem;
    logic [127:0] r_q;
    logic [63:0]  r_res;
    logic         r_err;

    // magnitudes of operands
    logic [63:0] w_mx, w_my;
    assign w_mx = i_req.lhs[63] ? (64'd0 - i_req.lhs) : i_req.lhs;
    assign w_my = i_req.rhs[63] ? (64'd0 - i_req.rhs) : i_req.rhs;

    // add and subtract with saturation
    logic [63:0] w_sum, w_dif;
    assign w_sum = i_req.lhs + i_req.rhs;
    assign w_dif = i_req.lhs - i_req.rhs;

    // partial product selection
    logic [31:0] w_pa, w_pb;
    logic [63:0] w_pp;
    always_comb begin
        w_pa = r_pp[1] ? r_x[63:32] : r_x[31:0];
        w_pb = r_pp[0] ? r_y[63:32] : r_y[31:0];
    end
    assign w_pp = w_pa * w_pb;

    // divide step
    logic [64:0] w_rsh, w_rsub;
    assign w_rsh  = {r_rem[63:0], r_num[127]};
    assign w_rsub = w_rsh - {1'b0, r_y};

    // saturating sign application on a 128-bit magnitude
    function automatic logic [64:0] f_sat(input logic [127:0] m, input logic neg);
        logic [63:0] lim;
        logic [64:0] r;
        lim = neg ? MINV : MAXV;
        if ((m[127:64] != 64'd0) || (m[63:0] > lim))
            r = {1'b1, neg ? MINV : MAXV};
        else
            r = {1'b0, neg ? (64'd0 - m[63:0]) : m[63:0]};
        return r;
    endfunction

    logic [127:0] w_mshift;
    assign w_mshift = r_acc >> FRACTION_BITS;
    logic [64:0] w_msat, w_dsat;
    assign w_msat = f_sat(w_mshift, r_neg);
    assign w_dsat = f_sat(r_q, r_neg);

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            A_IDLE: begin
                if (i_req.start) begin
                    if (i_req.op == ALU_MUL) n_st = A_MUL;
                    else if (i_req.op == ALU_DIV && i_req.rhs != 64'd0) n_st = A_DIV;
                    else n_st = A_DONE;
                end
            end
            A_MUL:    if (r_pp == 2'd3) n_st = A_MULFIN;
            A_MULFIN: n_st = A_DONE;
            A_DIV:    if (r_cnt == 7'd127) n_st = A_DIVFIN;
            A_DIVFIN: n_st = A_DONE;
            A_DONE:   n_st = A_IDLE;
            default:  n_st = A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= A_IDLE;
        else r_st <= n_st;
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_st)
            A_IDLE: begin
                r_x   <= w_mx;
                r_y   <= w_my;
                r_neg <= i_req.lhs[63] ^ i_req.rhs[63];
                r_acc <= 128'd0;
                r_pp  <= 2'd0;
                r_cnt <= 7'd0;
                r_rem <= 65'd0;
                r_q   <= 128'd0;
                r_num <= {64'd0, w_mx} << FRACTION_BITS;
                r_err <= 1'b0;
                case (i_req.op)
                    ALU_ADD: begin
                        if (i_req.lhs[63] == i_req.rhs[63] && w_sum[63] != i_req.lhs[63]) begin
                            r_res <= i_req.lhs[63] ? MINV : MAXV;
                            r_err <= 1'b1;
                        end else r_res <= w_sum;
                    end
                    ALU_SUB: begin
                        if (i_req.lhs[63] != i_req.rhs[63] && w_dif[63] != i_req.lhs[63]) begin
                            r_res <= i_req.lhs[63] ? MINV : MAXV;
                            r_err <= 1'b1;
                        end else r_res <= w_dif;
                    end
                    ALU_DIV: begin
                        r_res <= i_req.lhs[63] ? MINV : MAXV;
                        r_err <= 1'b1;
                    end
                    default: r_res <= i_req.rhs;
                endcase
            end
            A_MUL: begin
                r_acc <= r_acc + ({64'd0, w_pp} <<
                         {{1'b0, r_pp[1]} + {1'b0, r_pp[0]}, 5'd0});
                r_pp  <= r_pp + 2'd1;
            end
            A_MULFIN: begin
                r_res <= w_msat[63:0];
                r_err <= w_msat[64];
            end
            A_DIV: begin
                r_num <= {r_num[126:0], 1'b0};
                r_cnt <= r_cnt + 7'd1;
                if (r_rem[63] || !w_rsub[64]) begin
                    r_rem <= w_rsub;
                    r_q   <= {r_q[126:0], 1'b1};
                end else begin
                    r_rem <= w_rsh;
                    r_q   <= {r_q[126:0], 1'b0};
                end
            end
            A_DIVFIN: begin
                r_res <= w_dsat[63:0];
                r_err <= w_dsat[64];
            end
            default: ;
        endcase
    end

    assign o_rsp.done   = (r_st == A_DONE);
    assign o_rsp.err    = r_err;
    assign o_rsp.result = r_res;

    // assertions
    a_done_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.done |=> !o_rsp.done) else $error("done held two cycles");
    a_pp_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == A_MULFIN) |-> (r_pp == 2'd0)) else $error("partial product count off");
    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == A_DIVFIN) |-> $past(r_cnt) == 7'd127) else $error("divide step count off");
endmodule
`default_nettype wire
